/* sv/lpdf_pkg.sv */
// Shared types and constants for the lidar point decimation filter.
package lpdf_pkg;

  localparam int unsigned CFG_ADDR_W = 2;
  localparam int unsigned CFG_DATA_W = 16;

  localparam int unsigned STEP_W     = 8;
  localparam int unsigned BLIND_W    = 16;
  localparam int unsigned LINES_W    = 8;
  localparam int unsigned BLIND_SQ_W = 2 * BLIND_W;

  localparam int unsigned REFL_W = 8;
  localparam int unsigned TAG_W  = 8;
  localparam int unsigned LINE_W = 8;
  localparam int unsigned TIME_W = 32;

  localparam logic [STEP_W-1:0]  STEP_RST  = 8'd1;
  localparam logic [BLIND_W-1:0] BLIND_RST = 16'd10;
  localparam logic [LINES_W-1:0] LINES_RST = 8'd6;

  // return order lives in tag bits 5:4
  localparam int unsigned TAG_RET_LO = 4;
  localparam int unsigned TAG_RET_HI = 5;
  localparam logic [1:0]  RET_FIRST  = 2'b00;
  localparam logic [1:0]  RET_SECOND = 2'b01;

  typedef enum logic [CFG_ADDR_W-1:0] {
    CFG_STEP  = 2'd0,
    CFG_BLIND = 2'd1,
    CFG_LINES = 2'd2
  } cfg_reg_e;

  typedef struct packed {
    logic keep;     // valid point that survived decimation
    logic differs;  // differs from the stored point: the last advanced point if kept, else zero
  } lpdf_pick_t;

endpackage

/* sv/lpdf_square.sv */
// Magnitude and square of one signed coordinate.
module lpdf_square #(
  parameter int unsigned COORD_BITS = 24
) (
  input  logic signed [COORD_BITS-1:0]   coord_i,
  output logic        [2*COORD_BITS-1:0] square_o
);

  logic [COORD_BITS-1:0]   mag;
  logic [2*COORD_BITS-1:0] mag_w;

  assign mag      = coord_i[COORD_BITS-1] ? (~coord_i + 1'b1) : coord_i;
  assign mag_w    = {{COORD_BITS{1'b0}}, mag};
  assign square_o = mag_w * mag_w;

endmodule

/* sv/lpdf_select.sv */
// Frame reset, validity check, decimation counter and previous-point compare.
module lpdf_select #(
  parameter int unsigned COORD_BITS = 24
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic [lpdf_pkg::STEP_W-1:0]    step_i,
  input  logic [lpdf_pkg::LINES_W-1:0]   lines_i,
  input  logic                           adv_i,
  input  logic                           frame_i,
  input  logic [COORD_BITS-1:0]          x_i,
  input  logic [COORD_BITS-1:0]          y_i,
  input  logic [COORD_BITS-1:0]          z_i,
  input  logic [lpdf_pkg::TAG_W-1:0]     tag_i,
  input  logic [lpdf_pkg::LINE_W-1:0]    line_i,
  output lpdf_pkg::lpdf_pick_t           pick_o
);
  import lpdf_pkg::*;

  logic [STEP_W-1:0]     count_q, count_d;
  logic [COORD_BITS-1:0] prev_x_q, prev_x_d;
  logic [COORD_BITS-1:0] prev_y_q, prev_y_d;
  logic [COORD_BITS-1:0] prev_z_q, prev_z_d;
  logic [1:0]            ret;
  logic                  valid;
  logic [STEP_W:0]       count_inc;
  logic                  reached;

  assign ret       = tag_i[TAG_RET_HI:TAG_RET_LO];
  assign valid     = (line_i < lines_i) && ((ret == RET_FIRST) || (ret == RET_SECOND));
  assign count_inc = {1'b0, count_q} + 1'b1;
  // a step of zero acts as one: count_inc is never below it
  assign reached   = count_inc >= {1'b0, step_i};

  always_comb begin
    count_d        = count_q;
    prev_x_d       = '0;
    prev_y_d       = '0;
    prev_z_d       = '0;
    pick_o.keep    = 1'b0;
    pick_o.differs = (x_i != prev_x_q) || (y_i != prev_y_q) || (z_i != prev_z_q);
    if (frame_i) begin
      count_d = '0;
    end else if (valid) begin
      if (reached) begin
        count_d     = '0;
        pick_o.keep = 1'b1;
        prev_x_d    = x_i;
        prev_y_d    = y_i;
        prev_z_d    = z_i;
      end else begin
        count_d = count_inc[STEP_W-1:0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q  <= '0;
      prev_x_q <= '0;
      prev_y_q <= '0;
      prev_z_q <= '0;
    end else if (adv_i) begin
      count_q  <= count_d;
      prev_x_q <= prev_x_d;
      prev_y_q <= prev_y_d;
      prev_z_q <= prev_z_d;
    end
  end

  a_frame_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    adv_i && frame_i |=> count_q == '0 && prev_x_q == '0 && prev_y_q == '0 && prev_z_q == '0)
    else $error("frame start did not clear selection state");

  a_count_max: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q != {STEP_W{1'b1}})
    else $error("decimation counter overran");

endmodule

/* sv/lidar_point_decimate_filter.sv */
// Lidar point decimation and blind-zone filter, top level.
// Takes one point per clock while s_axis_tready is high and gives at most one point per
// accepted point. Three registered stages carry an accepted point to the output: the input
// register, where the frame, validity, decimation and previous-point checks update the
// state; the square register, fed by three coordinate squarers; and the output register,
// loaded after the sum of squares is compared with blind_mm squared. s_axis_tready
// follows m_axis_tready through the stage valids, so a stalled output holds up to three
// points in flight. Configuration writes take effect on the next clock and are meant for
// idle periods; blind_mm squared is registered at write time.
module lidar_point_decimate_filter #(
  parameter int unsigned COORD_BITS = 24,
  localparam int unsigned IN_RAW_W  = 3 * COORD_BITS + 56,
  localparam int unsigned IN_W      = ((IN_RAW_W + 7) / 8) * 8,
  localparam int unsigned OUT_RAW_W = 3 * COORD_BITS + 40,
  localparam int unsigned OUT_W     = ((OUT_RAW_W + 7) / 8) * 8
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [lpdf_pkg::CFG_ADDR_W-1:0]   cfg_addr_i,
  input  logic [lpdf_pkg::CFG_DATA_W-1:0]   cfg_wdata_i,
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  // pos_x, pos_y, pos_z, reflectivity, tag, line_number, offset_time_ns, zero pad
  input  logic [IN_W-1:0]                   s_axis_tdata,
  // frame_start
  input  logic                              s_axis_tuser,
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  // out_x, out_y, out_z, intensity, time_ns, zero pad
  output logic [OUT_W-1:0]                  m_axis_tdata
);
  import lpdf_pkg::*;

  localparam int unsigned CB       = COORD_BITS;
  localparam int unsigned SQ_W     = 2 * CB;
  localparam int unsigned DIST_W   = SQ_W + 2;
  localparam int unsigned REFL_LSB = 3 * CB;
  localparam int unsigned TAG_LSB  = REFL_LSB + REFL_W;
  localparam int unsigned LINE_LSB = TAG_LSB + TAG_W;
  localparam int unsigned TIME_LSB = LINE_LSB + LINE_W;

  // configuration
  logic [STEP_W-1:0]     step_q;
  logic [LINES_W-1:0]    lines_q;
  logic [BLIND_SQ_W-1:0] blind_sq_q;
  logic [BLIND_W-1:0]    wblind;

  assign wblind = cfg_wdata_i[BLIND_W-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q     <= STEP_RST;
      lines_q    <= LINES_RST;
      blind_sq_q <= BLIND_SQ_W'({{BLIND_W{1'b0}}, BLIND_RST} * {{BLIND_W{1'b0}}, BLIND_RST});
    end else if (cfg_we_i) begin
      unique case (cfg_reg_e'(cfg_addr_i))
        CFG_STEP:  step_q     <= cfg_wdata_i[STEP_W-1:0];
        CFG_BLIND: blind_sq_q <= {{BLIND_W{1'b0}}, wblind} * {{BLIND_W{1'b0}}, wblind};
        CFG_LINES: lines_q    <= cfg_wdata_i[LINES_W-1:0];
        default: ;
      endcase
    end
  end

  // stage enables
  logic v1_q, v2_q, v3_q;
  logic en1, en2, en3, adv;

  assign en3           = !v3_q || m_axis_tready;
  assign en2           = !v2_q || en3;
  assign en1           = !v1_q || en2;
  assign adv           = v1_q && en2;
  assign s_axis_tready = en1;
  assign m_axis_tvalid = v3_q;

  // stage 1: input register
  logic                  frame1_q;
  logic [CB-1:0]         x1_q, y1_q, z1_q;
  logic [REFL_W-1:0]     refl1_q;
  logic [TAG_W-1:0]      tag1_q;
  logic [LINE_W-1:0]     line1_q;
  logic [TIME_W-1:0]     time1_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
    end else if (en1) begin
      v1_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en1 && s_axis_tvalid) begin
      frame1_q <= s_axis_tuser;
      x1_q     <= s_axis_tdata[CB-1:0];
      y1_q     <= s_axis_tdata[2*CB-1:CB];
      z1_q     <= s_axis_tdata[3*CB-1:2*CB];
      refl1_q  <= s_axis_tdata[REFL_LSB +: REFL_W];
      tag1_q   <= s_axis_tdata[TAG_LSB +: TAG_W];
      line1_q  <= s_axis_tdata[LINE_LSB +: LINE_W];
      time1_q  <= s_axis_tdata[TIME_LSB +: TIME_W];
    end
  end

  lpdf_pick_t pick;

  lpdf_select #(
    .COORD_BITS (CB)
  ) u_select (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .step_i  (step_q),
    .lines_i (lines_q),
    .adv_i   (adv),
    .frame_i (frame1_q),
    .x_i     (x1_q),
    .y_i     (y1_q),
    .z_i     (z1_q),
    .tag_i   (tag1_q),
    .line_i  (line1_q),
    .pick_o  (pick)
  );

  logic [SQ_W-1:0] sqx, sqy, sqz;

  lpdf_square #(.COORD_BITS (CB)) u_sq_x (.coord_i (x1_q), .square_o (sqx));
  lpdf_square #(.COORD_BITS (CB)) u_sq_y (.coord_i (y1_q), .square_o (sqy));
  lpdf_square #(.COORD_BITS (CB)) u_sq_z (.coord_i (z1_q), .square_o (sqz));

  // stage 2: squares of kept points
  logic [SQ_W-1:0]   sqx2_q, sqy2_q, sqz2_q;
  logic [CB-1:0]     x2_q, y2_q, z2_q;
  logic [REFL_W-1:0] refl2_q;
  logic [TIME_W-1:0] time2_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v2_q <= 1'b0;
    end else if (en2) begin
      v2_q <= v1_q && !frame1_q && pick.keep && pick.differs;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en2) begin
      sqx2_q  <= sqx;
      sqy2_q  <= sqy;
      sqz2_q  <= sqz;
      x2_q    <= x1_q;
      y2_q    <= y1_q;
      z2_q    <= z1_q;
      refl2_q <= refl1_q;
      time2_q <= time1_q;
    end
  end

  // stage 3: blind-zone compare and output register
  logic [DIST_W-1:0] sum_sq;
  logic              far;

  assign sum_sq = {2'b00, sqx2_q} + {2'b00, sqy2_q} + {2'b00, sqz2_q};
  assign far    = sum_sq > {{(DIST_W - BLIND_SQ_W){1'b0}}, blind_sq_q};

  logic [OUT_RAW_W-1:0] out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v3_q <= 1'b0;
    end else if (en3) begin
      v3_q <= v2_q && far;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en3 && v2_q) begin
      out_q <= {time2_q, refl2_q, z2_q, y2_q, x2_q};
    end
  end

  always_comb begin
    m_axis_tdata                = '0;
    m_axis_tdata[OUT_RAW_W-1:0] = out_q;
  end

  a_out_from_stage2: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid) |-> $past(v2_q))
    else $error("output beat without a kept point behind it");

  a_stall_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready |-> v1_q && v2_q && v3_q && !m_axis_tready)
    else $error("input stalled with room in the pipeline");

endmodule
